@@ src/udpw_pkg.sv @@
package udpw_pkg;

  // One captured pulse symbol, as it arrives on the input channel.
  typedef struct packed {
    logic        first_level;
    logic [14:0] first_duration;
    logic        second_level;
    logic [14:0] second_duration;
    logic        last_symbol;
  } udpw_in_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last_byte;
  } udpw_out_t;

  // Configuration register indexes.
  localparam logic REG_BIT_TIME  = 1'b0;
  localparam logic REG_MAX_BYTES = 1'b1;

  // Timing and limit constants of the 8N1 decode.
  localparam int unsigned IDLE_US     = 3000;
  localparam int unsigned STOP_FACTOR = 19;
  localparam int unsigned FRAME_BITS  = 10;
  localparam int unsigned OUT_LIMIT   = 64;
  localparam int unsigned STOP_INDEX  = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic append;
    logic scan_rd;
    logic scan_skip;
    logic edge_take;
    logic samp_rd;
    logic samp_hit;
    logic samp_adv;
    logic frame_ok;
    logic frame_drop;
    logic push_mid;
    logic push_final;
  } udpw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_hold;
    logic scan_done;
    logic edge_found;
    logic s_in;
    logic at_end;
    logic k_stop;
    logic stop_high;
    logic pend_valid;
    logic out_free;
  } udpw_stat_t;

endpackage

@@ src/udpw_ctrl.sv @@
module udpw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  udpw_pkg::udpw_stat_t st,
  output udpw_pkg::udpw_cmd_t  cmd
);
  import udpw_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEG2     = 9'b000000010,
    S_APPEND   = 9'b000000100,
    S_SCAN_RD  = 9'b000001000,
    S_SCAN_CHK = 9'b000010000,
    S_SAMP_RD  = 9'b000100000,
    S_SAMP_CHK = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Input is taken only between bursts and between symbols.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_first = 1'b1;
          state_nxt      = S_SEG2;
        end
      end
      S_SEG2: begin
        cmd.load_second = 1'b1;
        state_nxt       = st.last_hold ? S_APPEND : S_IDLE;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (st.scan_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.edge_found) begin
          cmd.edge_take = 1'b1;
          state_nxt     = S_SAMP_RD;
        end else begin
          cmd.scan_skip = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SAMP_RD: begin
        cmd.samp_rd = 1'b1;
        state_nxt   = S_SAMP_CHK;
      end
      S_SAMP_CHK: begin
        if (st.s_in) begin
          if (!st.k_stop) begin
            cmd.samp_hit = 1'b1;
            state_nxt    = S_SAMP_RD;
          end else if (st.stop_high) begin
            cmd.frame_ok = 1'b1;
            state_nxt    = st.pend_valid ? S_EMIT : S_SCAN_RD;
          end else begin
            cmd.frame_drop = 1'b1;
            state_nxt      = S_SCAN_RD;
          end
        end else if (st.at_end) begin
          cmd.frame_drop = 1'b1;
          state_nxt      = S_SCAN_RD;
        end else begin
          cmd.samp_adv = 1'b1;
          state_nxt    = S_SAMP_RD;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.push_mid = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.push_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/udpw_dpath.sv @@
module udpw_dpath #(
  parameter int SYMBOLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  udpw_pkg::udpw_in_t  in_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_wdata,
  input  logic                out_stall,
  output logic                out_valid,
  output udpw_pkg::udpw_out_t out_data,
  input  udpw_pkg::udpw_cmd_t  cmd,
  output udpw_pkg::udpw_stat_t st
);
  import udpw_pkg::*;

  localparam int DEPTH = 2 * SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = $clog2(SYMBOLS + 1);
  localparam int TW    = $clog2(DEPTH * 32767 + IDLE_US + 1);
  localparam int SW    = ((TW > 20) ? TW : 20) + 1;
  localparam int MW    = TW + 1;

  // Configuration registers.
  logic [15:0] bit_r;
  logic [6:0]  max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r       <= 16'd104;
      max_bytes_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BIT_TIME:  bit_r       <= cfg_wdata;
        REG_MAX_BYTES: max_bytes_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Burst loading state.
  logic [CW-1:0] total_r;
  logic [KW-1:0] taken_r;
  logic [TW-1:0] cursor_r;
  logic          take_r;
  logic          last_r;
  logic          sec_lvl_r;
  logic [14:0]   sec_dur_r;

  // Scan and sampling state.
  logic [TW-1:0] line_end_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] j_r;
  logic [6:0]    count_r;
  logic [SW-1:0] not_before_r;
  logic          prev_r;
  logic [TW-1:0] t_r;
  logic          jlvl_r;
  logic [3:0]    k_r;
  logic [7:0]    val_r;
  logic [SW-1:0] s_r;
  logic [7:0]    pend_r;
  logic          pend_valid_r;

  // Output register.
  logic          out_valid_r;
  udpw_out_t     out_r;

  // Segment memory: level in the top bit, start time below.
  logic [MW-1:0] seg_mem [DEPTH];
  logic [MW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  logic          take;
  logic          room;
  logic          add_ok;
  logic          add_lvl;
  logic [14:0]   add_dur;
  logic          add_en;
  logic          rd_lvl;
  logic [TW-1:0] rd_start;
  logic [6:0]    limit;
  logic [4:0]    factor;
  logic [20:0]   prod;
  logic [TW-1:0] seg_end;
  logic          out_free;

  assign take     = (taken_r < KW'(SYMBOLS));
  assign room     = (total_r < CW'(DEPTH));
  assign rd_lvl   = rd_data_r[MW-1];
  assign rd_start = rd_data_r[TW-1:0];
  assign limit    = (max_bytes_r > 7'(OUT_LIMIT)) ? 7'(OUT_LIMIT) : max_bytes_r;
  assign out_free = !out_valid_r || !out_stall;

  // Segment to add: the first half straight from the port, the second from the hold.
  always_comb begin
    add_ok  = 1'b0;
    add_lvl = 1'b0;
    add_dur = '0;
    if (cmd.load_first) begin
      add_ok  = take;
      add_lvl = in_data.first_level;
      add_dur = in_data.first_duration;
    end else if (cmd.load_second) begin
      add_ok  = take_r;
      add_lvl = sec_lvl_r;
      add_dur = sec_dur_r;
    end
  end

  assign add_en  = add_ok && (add_dur != '0) && room;
  assign wr_en   = add_en || (cmd.append && room);
  assign wr_addr = total_r[AW-1:0];
  assign wr_data = {(cmd.append ? 1'b1 : add_lvl), cursor_r};

  // Read address: the scanned segment, or the one after the sampling pointer.
  assign rd_en   = cmd.scan_rd || cmd.samp_rd;
  assign rd_addr = cmd.scan_rd ? i_r[AW-1:0] : AW'(j_r + CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= seg_mem[rd_addr];
    end
  end

  // Sample offset: floor(factor * bit / 2), factor 3 + 2k for data, 19 for stop.
  assign factor = (k_r == 4'(STOP_INDEX)) ? 5'(STOP_FACTOR) : {k_r[2:0], 1'b1} + 5'd2;
  assign prod   = 21'(factor) * 21'(bit_r);

  // End of the segment under the sampling pointer.
  assign seg_end = st.at_end ? line_end_r : rd_start;

  assign st.last_hold  = last_r;
  assign st.scan_done  = (i_r >= total_r) || (count_r >= limit);
  assign st.edge_found = !rd_lvl && prev_r && (SW'(rd_start) >= not_before_r);
  assign st.at_end     = ((j_r + CW'(1)) == total_r);
  assign st.s_in       = (s_r < SW'(seg_end));
  assign st.k_stop     = (k_r == 4'(STOP_INDEX));
  assign st.stop_high  = jlvl_r;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;

  // Control registers of the burst and the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      taken_r      <= '0;
      cursor_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (add_en) begin
        total_r  <= total_r + CW'(1);
        cursor_r <= cursor_r + TW'(add_dur);
      end
      if (cmd.append && room) begin
        total_r <= total_r + CW'(1);
      end
      if (cmd.load_first && take) begin
        taken_r <= taken_r + KW'(1);
      end
      if (cmd.frame_ok) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.push_mid || cmd.push_final) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.push_final) begin
        pend_valid_r <= 1'b0;
        total_r      <= '0;
        taken_r      <= '0;
        cursor_r     <= '0;
      end
    end
  end

  // Datapath registers of the decode walk.
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      take_r    <= take;
      last_r    <= in_data.last_symbol;
      sec_lvl_r <= in_data.second_level;
      sec_dur_r <= in_data.second_duration;
    end
    if (cmd.append) begin
      line_end_r   <= room ? cursor_r + TW'(IDLE_US) : cursor_r;
      i_r          <= '0;
      count_r      <= '0;
      not_before_r <= '0;
      prev_r       <= 1'b1;
    end
    if (cmd.scan_skip) begin
      prev_r <= rd_lvl;
      i_r    <= i_r + CW'(1);
    end
    if (cmd.edge_take) begin
      prev_r <= rd_lvl;
      t_r    <= rd_start;
      j_r    <= i_r;
      jlvl_r <= rd_lvl;
      k_r    <= '0;
      val_r  <= '0;
    end
    if (cmd.samp_rd) begin
      s_r <= SW'(t_r) + SW'(prod[20:1]);
    end
    if (cmd.samp_hit) begin
      val_r[k_r[2:0]] <= jlvl_r;
      k_r             <= k_r + 4'd1;
    end
    if (cmd.samp_adv) begin
      j_r    <= j_r + CW'(1);
      jlvl_r <= rd_lvl;
    end
    if (cmd.frame_drop) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.frame_ok) begin
      i_r          <= i_r + CW'(1);
      count_r      <= count_r + 7'd1;
      not_before_r <= SW'(t_r) + SW'(bit_r) * SW'(FRAME_BITS);
      if (!pend_valid_r) begin
        pend_r <= val_r;
      end
    end
    if (cmd.push_mid) begin
      out_r  <= '{byte_value: pend_r, has_byte: 1'b1, last_byte: 1'b0};
      pend_r <= val_r;
    end
    if (cmd.push_final) begin
      if (pend_valid_r) begin
        out_r <= '{byte_value: pend_r, has_byte: 1'b1, last_byte: 1'b1};
      end else begin
        out_r <= '{byte_value: 8'd0, has_byte: 1'b0, last_byte: 1'b1};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ src/uart_decode_from_pulse_widths.sv @@
// UART 8N1 receiver that works from captured pulse durations.
// Input channel (in_valid/in_stall/in_data): one pulse symbol per transaction,
// two level/duration halves in microseconds; zero-length halves are skipped.
// Each symbol is loaded into the segment memory one half per cycle (the
// memory has a single write port). A symbol with last_symbol set starts
// the decode of the burst.
// Decode walks the segment memory through its single registered read port:
// it appends the idle segment when the memory has room, scans the segments
// for start edges, reads and checks each sample step and each segment
// boundary crossed inside a frame, and hands each result to the output register.
// Results leave on out_valid/out_stall/out_data, one per transaction, the
// final one marked by last_byte; an empty burst gives one result with
// has_byte low. in_stall is high while a symbol is loaded or a burst is
// decoded. When the receiver stalls, the result holds in the output
// register and the decode waits at the next byte. Configuration
// (cfg_we/cfg_addr/cfg_wdata) is to be written only while idle; the block
// does not enforce it. Reset restores bit time 104 us and max_bytes 64 and
// empties the burst; the segment memory needs no clearing.
module uart_decode_from_pulse_widths #(
  parameter int SYMBOLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  udpw_pkg::udpw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output udpw_pkg::udpw_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_wdata
);
  import udpw_pkg::*;

  udpw_cmd_t  cmd;
  udpw_stat_t st;

  // Sequencer.
  udpw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Segment store, sampling arithmetic and output register.
  udpw_dpath #(
    .SYMBOLS (SYMBOLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

`ifndef SYNTHESIS
  // Once a symbol is taken, in_stall goes high before another can be taken.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // An empty result is always the final one of its burst.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.last_byte)
    else $error("empty result not marked last");

  // An empty result carries a zero byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.byte_value == 8'd0)
    else $error("empty result with nonzero byte");

  // No new results come out while the decoder waits for a symbol.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared while idle");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import udpw_pkg::*;

  localparam int unsigned SYMBOLS   = 64;
  localparam int unsigned SEG_DEPTH = 2 * SYMBOLS;

  // Predicts the bytes that each burst of pulse symbols decodes to and
  // checks every result transaction against the oldest prediction.
  class byte_scoreboard;
    bit          seg_level [SEG_DEPTH];
    int unsigned seg_start [SEG_DEPTH];
    int unsigned seg_count;
    int unsigned symbols_held;
    int unsigned cursor;
    int unsigned bit_us;
    int unsigned byte_cap;
    udpw_out_t   expected_bytes [$];

    function new();
      seg_count    = 0;
      symbols_held = 0;
      cursor       = 0;
      bit_us       = 104;
      byte_cap     = 64;
    endfunction

    function void write_register(logic addr, logic [15:0] value);
      if (addr == REG_BIT_TIME) begin
        bit_us = 32'(value);
      end else begin
        byte_cap = 32'(value[6:0]);
      end
    endfunction

    // Zero-length halves and halves past the end of the store are dropped.
    function void place_half(logic lvl, logic [14:0] dur);
      if (dur == 0 || seg_count >= SEG_DEPTH) return;
      seg_level[seg_count] = lvl;
      seg_start[seg_count] = cursor;
      seg_count++;
      cursor += dur;
    endfunction

    // Line level at time t, or -1 when t is off the time line.
    function int level_at(int unsigned t, int unsigned line_end);
      int unsigned e;
      for (int unsigned i = 0; i < seg_count; i++) begin
        e = (i + 1 < seg_count) ? seg_start[i + 1] : line_end;
        if (t >= seg_start[i] && t < e) return seg_level[i];
      end
      return -1;
    endfunction

    function void decode_burst();
      int unsigned line_end;
      int unsigned cap;
      int unsigned not_before;
      int unsigned t;
      logic [7:0]  value;
      bit          framed;
      bit          whole;
      int          lv;
      udpw_out_t   r;
      udpw_out_t   found [$];
      line_end   = cursor;
      cap        = (byte_cap > OUT_LIMIT) ? OUT_LIMIT : byte_cap;
      not_before = 0;
      // The idle tail only fits when the store has room left.
      if (seg_count < SEG_DEPTH) begin
        seg_level[seg_count] = 1'b1;
        seg_start[seg_count] = cursor;
        seg_count++;
        line_end = cursor + IDLE_US;
      end
      for (int unsigned i = 0; i < seg_count && found.size() < cap; i++) begin
        t      = seg_start[i];
        framed = seg_level[i] == 1'b0 && (i == 0 || seg_level[i - 1] == 1'b1);
        if (!framed || t < not_before) continue;
        value = '0;
        whole = 1'b1;
        for (int unsigned k = 0; k < 8; k++) begin
          lv = level_at(t + ((3 + 2 * k) * bit_us) / 2, line_end);
          if (lv < 0) begin
            whole = 1'b0;
            break;
          end
          value[k] = (lv == 1);
        end
        if (whole && level_at(t + (STOP_FACTOR * bit_us) / 2, line_end) == 1) begin
          r.byte_value = value;
          r.has_byte   = 1'b1;
          r.last_byte  = 1'b0;
          found.push_back(r);
          not_before = t + FRAME_BITS * bit_us;
        end
      end
      if (found.size() == 0) begin
        r = '0;
        r.last_byte = 1'b1;
        expected_bytes.push_back(r);
      end else begin
        foreach (found[j]) begin
          r = found[j];
          r.last_byte = (j == found.size() - 1);
          expected_bytes.push_back(r);
        end
      end
    endfunction

    // Called for every accepted input transaction.
    function void take_symbol(udpw_in_t s);
      if (symbols_held < SYMBOLS) begin
        place_half(s.first_level, s.first_duration);
        place_half(s.second_level, s.second_duration);
        symbols_held++;
      end
      if (s.last_symbol) begin
        decode_burst();
        seg_count    = 0;
        symbols_held = 0;
        cursor       = 0;
      end
    endfunction

    // Returns an empty string when the result matches the oldest prediction.
    function string check_byte(udpw_out_t got);
      udpw_out_t want;
      if (expected_bytes.size() == 0) begin
        return $sformatf("result %02h/%b/%b arrived with nothing expected",
                         got.byte_value, got.has_byte, got.last_byte);
      end
      want = expected_bytes.pop_front();
      if (got.byte_value !== want.byte_value || got.has_byte !== want.has_byte ||
          got.last_byte !== want.last_byte) begin
        return $sformatf("byte %02h want %02h, has_byte %b want %b, last_byte %b want %b",
                         got.byte_value, want.byte_value, got.has_byte, want.has_byte,
                         got.last_byte, want.last_byte);
      end
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  udpw_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  udpw_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  byte_scoreboard board;
  int          errors = 0;
  int unsigned items_sent = 0;
  bit          calm = 1'b0;
  bit          jitter = 1'b0;

  // Line segments of the burst under construction.
  bit          run_level [$];
  int unsigned run_length [$];

  uart_decode_from_pulse_widths dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Idle cycles before the next transaction on either side.
  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic int unsigned stretch(int unsigned bt);
    if (!jitter || bt < 16) return bt;
    return bt - bt / 16 + $urandom_range(0, bt / 8);
  endfunction

  function automatic int unsigned noise_length(int unsigned bt);
    int unsigned span;
    span = (bt * 3 > 32766) ? 32766 : bt * 3;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 32767);
      2: return 32767;
      default: return $urandom_range(1, span + 1);
    endcase
  endfunction

  // Valid stays high between back-to-back transactions.
  task automatic send_symbol(udpw_in_t s);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_symbol(s);
    items_sent++;
  endtask

  task automatic send_fields(bit l1, int unsigned d1, bit l2, int unsigned d2, bit last);
    udpw_in_t s;
    s.first_level     = l1;
    s.first_duration  = 15'(d1);
    s.second_level    = l2;
    s.second_duration = 15'(d2);
    s.last_symbol     = last;
    send_symbol(s);
  endtask

  task automatic add_run(bit lvl, int unsigned len);
    if (len == 0) return;
    if (run_level.size() != 0 && run_level[run_level.size() - 1] == lvl) begin
      run_length[run_length.size() - 1] = run_length[run_length.size() - 1] + len;
    end else begin
      run_level.push_back(lvl);
      run_length.push_back(len);
    end
  endtask

  // Start bit, eight data bits LSB first, then a stop bit that may be broken.
  task automatic add_byte_frame(logic [7:0] data_byte, int unsigned bt, bit stop_ok);
    add_run(1'b0, stretch(bt));
    for (int k = 0; k < 8; k++) add_run(data_byte[k], stretch(bt));
    add_run(stop_ok, stretch(bt));
  endtask

  // Cuts the runs into halves, pairs them into symbols and sends the burst.
  // Long runs are split, sometimes at random points, and empty halves are
  // sprinkled in now and then.
  task automatic ship_runs();
    bit          half_lvl [$];
    int unsigned half_len [$];
    int unsigned rest;
    int unsigned piece;
    foreach (run_level[i]) begin
      rest = run_length[i];
      while (rest > 0) begin
        piece = (rest > 32767) ? 32767 : rest;
        if (piece > 1 && $urandom_range(0, 7) == 0) piece = $urandom_range(1, piece - 1);
        half_lvl.push_back(run_level[i]);
        half_len.push_back(piece);
        rest -= piece;
        if ($urandom_range(0, 19) == 0) begin
          half_lvl.push_back(1'($urandom_range(0, 1)));
          half_len.push_back(0);
        end
      end
    end
    while (half_lvl.size() == 0 || half_lvl.size() % 2 != 0) begin
      half_lvl.push_back(1'($urandom_range(0, 1)));
      half_len.push_back(0);
    end
    for (int i = 0; i < half_lvl.size(); i += 2) begin
      send_fields(half_lvl[i], half_len[i], half_lvl[i + 1], half_len[i + 1],
                  i + 2 >= half_lvl.size());
    end
    run_level.delete();
    run_length.delete();
  endtask

  // A burst of frames, some with a low stop bit; a broken one loses its tail.
  task automatic uart_burst(int unsigned bt, bit broken);
    int unsigned n;
    int unsigned keep;
    if ($urandom_range(0, 2) != 0) add_run(1'b1, stretch(bt) * $urandom_range(1, 3));
    n = $urandom_range(1, 4);
    repeat (n) begin
      add_byte_frame(8'($urandom_range(0, 255)), bt, $urandom_range(0, 9) != 0);
      add_run(1'b1, $urandom_range(0, 2 * bt));
    end
    if (broken) begin
      keep = $urandom_range(1, run_level.size());
      while (run_level.size() > keep) begin
        void'(run_level.pop_back());
        void'(run_length.pop_back());
      end
    end
    ship_runs();
  endtask

  task automatic noise_burst(int unsigned bt);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_fields(1'($urandom_range(0, 1)), noise_length(bt), 1'($urandom_range(0, 1)),
                  noise_length(bt), i == n - 1);
    end
  endtask

  task automatic write_register(logic addr, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    board.write_register(addr, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stops the sender and waits until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic run_phase(logic [15:0] bt_reg, logic [6:0] cap_reg, int unsigned gen_bt,
                           int unsigned budget);
    int unsigned stop_at;
    int          pick;
    settle();
    write_register(REG_BIT_TIME, bt_reg);
    write_register(REG_MAX_BYTES, {9'($urandom), cap_reg});
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      calm   = ($urandom_range(0, 4) == 0);
      jitter = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      if (pick < 7) begin
        uart_burst(gen_bt, 1'b0);
      end else if (pick < 9) begin
        noise_burst(gen_bt);
      end else begin
        uart_burst(gen_bt, 1'b1);
      end
    end
  endtask

  // Result side: random stalls ahead of each transaction, then a check.
  initial begin : result_sink
    int    pause;
    string msg;
    wait (rst_n === 1'b1);
    forever begin
      pause = draw_wait();
      @(negedge clk);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      msg = board.check_byte(out_data);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin : stimulus
    board = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed bursts under the reset settings.
    send_fields(1'b0, 0, 1'b0, 0, 1'b1);
    add_run(1'b1, 300);
    add_byte_frame(8'h00, 104, 1'b1);
    add_byte_frame(8'hFF, 104, 1'b1);
    add_run(1'b1, 200);
    ship_runs();
    // Line low from time zero with a low stop bit.
    send_fields(1'b0, 1040, 1'b1, 500, 1'b1);
    send_fields(1'b1, 32767, 1'b0, 32767, 1'b0);
    send_fields(1'b0, 32767, 1'b1, 32767, 1'b1);
    add_byte_frame(8'hA5, 104, 1'b1);
    ship_runs();
    calm = 1'b1;
    add_byte_frame(8'h5A, 104, 1'b1);
    add_run(1'b1, 104);
    add_byte_frame(8'h3C, 104, 1'b0);
    add_byte_frame(8'hC3, 104, 1'b1);
    ship_runs();
    calm = 1'b0;
    send_fields(1'b1, 0, 1'b0, 0, 1'b0);
    send_fields(1'b0, 0, 1'b1, 0, 1'b1);

    // Random phases, each under its own settings.
    run_phase(16'd1, 7'd1, 1, 3);
    run_phase(16'hFFFF, 7'd64, 65535, 1);
    run_phase(16'd0, 7'd3, 50, 3);
    run_phase(16'd26, 7'd127, 26, 3);
    run_phase(16'd417, 7'd0, 417, 3);
    run_phase(16'd13, 7'd2, 13, 3);
    run_phase(16'($urandom_range(4, 300)), 7'($urandom_range(1, 64)), 104, 3);
    run_phase(16'd104, 7'd64, 104, 1);

    // A burst longer than the store: the tail symbols are dropped and no
    // idle segment fits.
    calm = 1'b0;
    for (int i = 0; i < 66; i++) begin
      send_fields(1'b1, $urandom_range(50, 400), 1'b0, $urandom_range(50, 400), i == 65);
    end

    settle();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
